// ----- hw/rtl/d2s_pkg.sv -----
// Shared types and constants for the depth-to-space address generator.
// No dependencies; every other file depends on this package.
`timescale 1ns / 1ps

package d2s_pkg;

  localparam int MAX_WIDTH    = 1024;
  localparam int MAX_HEIGHT   = 1024;
  localparam int MAX_TILE     = 16;
  localparam int MAX_CHANNELS = 64;
  localparam int ADDR_BITS    = 32;

  localparam int DIM_W   = 11;  // tensor_width / tensor_height register width
  localparam int TILE_W  = 5;   // tile edge register width
  localparam int CHAN_W  = 7;   // channels register width
  localparam int CFG_W   = 11;  // widest register
  localparam int ROW_CW  = 10;  // position counter widths
  localparam int COL_CW  = 10;
  localparam int CH_CW   = 6;
  localparam int TR_CW   = 4;
  localparam int TC_CW   = 4;
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = 2;

  typedef logic signed [7:0] sample_t;
  typedef logic [ADDR_BITS-1:0] addr_t;

  typedef enum logic [1:0] {
    CFG_TENSOR_WIDTH  = 2'd0,
    CFG_TENSOR_HEIGHT = 2'd1,
    CFG_TILE_EDGE     = 2'd2,
    CFG_CHANNELS      = 2'd3
  } cfg_index_t;

  // Effective (clamped) configuration seen by front and back.
  typedef struct packed {
    logic [DIM_W-1:0]  width;
    logic [DIM_W-1:0]  height;
    logic [TILE_W-1:0] tile;
    logic [CHAN_W-1:0] chans;
  } d2s_cfg_t;

  // One classified element waiting for address computation.
  typedef struct packed {
    sample_t           sample;
    logic [ROW_CW-1:0] row;
    logic [COL_CW-1:0] col;
    logic [CH_CW-1:0]  chan;
    logic [TR_CW-1:0]  trow;
    logic [TC_CW-1:0]  tcol;
    logic              last;
  } d2s_entry_t;

endpackage

// ----- hw/rtl/d2s_if.sv -----
// Stream interfaces for the depth-to-space address generator.
// Depends on d2s_pkg for payload types.
`timescale 1ns / 1ps

interface d2s_in_if;
  logic             valid;
  logic             ready;
  d2s_pkg::sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface d2s_out_if;
  logic             valid;
  logic             ready;
  d2s_pkg::sample_t out_value;
  d2s_pkg::addr_t   out_address;
  logic             frame_last;

  modport source (output valid, output out_value, output out_address,
                  output frame_last, input ready);
  modport sink   (input valid, input out_value, input out_address,
                  input frame_last, output ready);
endinterface

// ----- hw/rtl/depth_to_space_address_gen_unit.sv -----
// Depth-to-space address generator: one element per cycle sustained when the
// output is taken each cycle; the front queue accepts while the back stalls, until it is full.
// An accepted element is written to the queue, then passes three address stages
// (multiply-add, product, final add into the output register).
// A held output stalls the whole address pipeline.
// Reset (synchronous, rst high) sets all configuration registers to 1, clears the position
// counters and empties the queue and pipeline.
`timescale 1ns / 1ps

module depth_to_space_address_gen_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [d2s_pkg::CFG_W-1:0]  cfg_data,
  d2s_in_if.sink                     sample_ch,
  d2s_out_if.source                  result_ch
);
  import d2s_pkg::*;

  logic [DIM_W-1:0]  tensor_width;
  logic [DIM_W-1:0]  tensor_height;
  logic [TILE_W-1:0] tile_edge;
  logic [CHAN_W-1:0] channels;
  d2s_cfg_t          cfg;

  logic       q_push, q_pop, q_full, q_empty;
  d2s_entry_t q_wdata, q_rdata;

  // Zero acts as one; values above the maximum act as the maximum.
  function automatic logic [10:0] clamp_dim(input logic [10:0] v, input logic [10:0] maxv);
    logic [10:0] r;
    if (v == '0) r = 11'd1;
    else if (v > maxv) r = maxv;
    else r = v;
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      tensor_width  <= DIM_W'(1);
      tensor_height <= DIM_W'(1);
      tile_edge     <= TILE_W'(1);
      channels      <= CHAN_W'(1);
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_TENSOR_WIDTH:  tensor_width  <= cfg_data[DIM_W-1:0];
        CFG_TENSOR_HEIGHT: tensor_height <= cfg_data[DIM_W-1:0];
        CFG_TILE_EDGE:     tile_edge     <= cfg_data[TILE_W-1:0];
        CFG_CHANNELS:      channels      <= cfg_data[CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.width  = clamp_dim(tensor_width, 11'(MAX_WIDTH));
    cfg.height = clamp_dim(tensor_height, 11'(MAX_HEIGHT));
    cfg.tile   = TILE_W'(clamp_dim(11'(tile_edge), 11'(MAX_TILE)));
    cfg.chans  = CHAN_W'(clamp_dim(11'(channels), 11'(MAX_CHANNELS)));
  end

  d2s_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .sample_ch (sample_ch),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_wdata)
  );

  d2s_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  d2s_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .result_ch (result_ch)
  );

endmodule

// ----- hw/rtl/d2s_front.sv -----
// Front end: accepts elements, tracks the five nested position counters
// and marks the final element. Depends on d2s_pkg and d2s_in_if.
`timescale 1ns / 1ps

module d2s_front (
  input  logic                  clk,
  input  logic                  rst,
  input  d2s_pkg::d2s_cfg_t     cfg,
  d2s_in_if.sink                sample_ch,
  input  logic                  q_full,
  output logic                  q_push,
  output d2s_pkg::d2s_entry_t   q_data
);
  import d2s_pkg::*;

  logic [ROW_CW-1:0] row_count;
  logic [COL_CW-1:0] col_count;
  logic [CH_CW-1:0]  chan_count;
  logic [TR_CW-1:0]  tile_row_count;
  logic [TC_CW-1:0]  tile_col_count;

  logic tc_wrap, tr_wrap, ch_wrap, col_wrap, row_wrap;

  // A counter at or beyond its final position counts as final.
  assign tc_wrap  = ({2'b0, tile_col_count} + 6'd1) >= {1'b0, cfg.tile};
  assign tr_wrap  = ({2'b0, tile_row_count} + 6'd1) >= {1'b0, cfg.tile};
  assign ch_wrap  = ({1'b0, chan_count} + 7'd1) >= cfg.chans;
  assign col_wrap = ({1'b0, col_count} + 11'd1) >= cfg.width;
  assign row_wrap = ({1'b0, row_count} + 11'd1) >= cfg.height;

  assign sample_ch.ready = !q_full;
  assign q_push          = sample_ch.valid && !q_full;

  always_comb begin
    q_data.sample = sample_ch.sample;
    q_data.row    = row_count;
    q_data.col    = col_count;
    q_data.chan   = chan_count;
    q_data.trow   = tile_row_count;
    q_data.tcol   = tile_col_count;
    q_data.last   = tc_wrap && tr_wrap && ch_wrap && col_wrap && row_wrap;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count      <= '0;
      col_count      <= '0;
      chan_count     <= '0;
      tile_row_count <= '0;
      tile_col_count <= '0;
    end else if (q_push) begin
      if (!tc_wrap) begin
        tile_col_count <= tile_col_count + 1'b1;
      end else begin
        tile_col_count <= '0;
        if (!tr_wrap) begin
          tile_row_count <= tile_row_count + 1'b1;
        end else begin
          tile_row_count <= '0;
          if (!ch_wrap) begin
            chan_count <= chan_count + 1'b1;
          end else begin
            chan_count <= '0;
            if (!col_wrap) begin
              col_count <= col_count + 1'b1;
            end else begin
              col_count <= '0;
              row_count <= row_wrap ? '0 : row_count + 1'b1;
            end
          end
        end
      end
    end
  end

endmodule

// ----- hw/rtl/d2s_fifo.sv -----
// Short queue between front and back end, holding classified elements.
// Depends on d2s_pkg.
`timescale 1ns / 1ps

module d2s_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  d2s_pkg::d2s_entry_t push_data,
  output logic                full,
  input  logic                pop,
  output d2s_pkg::d2s_entry_t pop_data,
  output logic                empty
);
  import d2s_pkg::*;

  d2s_entry_t        entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full     = count == (QPTR_W+1)'(QDEPTH);
  assign empty    = count == '0;
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end
  end

endmodule

// ----- hw/rtl/d2s_back.sv -----
// Back end: three-stage address pipeline from queued counter values to the
// output register. Depends on d2s_pkg and d2s_out_if.
`timescale 1ns / 1ps

module d2s_back (
  input  logic                clk,
  input  logic                rst,
  input  d2s_pkg::d2s_cfg_t   cfg,
  input  logic                q_empty,
  input  d2s_pkg::d2s_entry_t q_data,
  output logic                q_pop,
  d2s_out_if.source           result_ch
);
  import d2s_pkg::*;

  logic adv;
  logic v1, v2, v3;

  // stage 1: output row/column and c*t
  logic [14:0]       oy1, ox1;
  logic [10:0]       ct1;
  logic [CH_CW-1:0]  ch1;
  sample_t           val1;
  logic              last1;
  // stage 2: partial products
  logic [24:0]       p2;
  logic [20:0]       lo2;
  sample_t           val2;
  logic              last2;
  // stage 3: output register
  addr_t             addr3;
  sample_t           val3;
  logic              last3;

  // Whole pipeline stalls together when the output is held.
  assign adv   = !v3 || result_ch.ready;
  assign q_pop = adv && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= !q_empty;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      oy1   <= 15'(q_data.row) * 15'(cfg.tile) + 15'(q_data.trow);
      ox1   <= 15'(q_data.col) * 15'(cfg.tile) + 15'(q_data.tcol);
      ct1   <= 11'(cfg.chans) * 11'(cfg.tile);
      ch1   <= q_data.chan;
      val1  <= q_data.sample;
      last1 <= q_data.last;

      p2    <= 25'(oy1) * 25'(ct1);
      lo2   <= 21'(ox1) * 21'(cfg.chans) + 21'(ch1);
      val2  <= val1;
      last2 <= last1;

      addr3 <= ADDR_BITS'(36'(p2) * 36'(cfg.width) + 36'(lo2));
      val3  <= val2;
      last3 <= last2;
    end
  end

  assign result_ch.valid       = v3;
  assign result_ch.out_value   = val3;
  assign result_ch.out_address = addr3;
  assign result_ch.frame_last  = last3;

endmodule
